// ===== design/abb_pkg.sv =====
package abb_pkg;

   // CORDIC depth and angle format.
   localparam int CORDIC_STAGES = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int NUM_LANES     = 3;
   localparam int LANE_START    = 0;
   localparam int LANE_END      = 1;
   localparam int LANE_AXIS     = 2;

   // Datapath widths.
   localparam int XY_BITS  = 50;
   localparam int Z_BITS   = 34;
   localparam int PT_BITS  = 36;
   localparam int IDX_BITS = 5;

   // Gain 0.6072529350088813 in Q0.32.
   localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

   // Arctangent of 2^-i in 2^32 units per turn.
   localparam logic [31:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   // One rotating vector.
   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic signed [Z_BITS-1:0]  z;
   } lane_type;

   // Side data that travels with an arc through the chain.
   typedef struct packed {
      logic               ok;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [1:0]         quad_start;
      logic [1:0]         quad_end;
      logic [3:0]         on_arc;
   } tag_type;

   typedef struct packed {
      logic signed [PT_BITS-1:0] x;
      logic signed [PT_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic signed [PT_BITS-1:0] lo_x;
      logic signed [PT_BITS-1:0] lo_y;
      logic signed [PT_BITS-1:0] hi_x;
      logic signed [PT_BITS-1:0] hi_y;
   } box_type;

   // Widen a box so that it covers a point.
   function automatic box_type grow(input box_type b, input point_type p);
      box_type r;
      r = b;
      if (p.x < r.lo_x) r.lo_x = p.x;
      if (p.x > r.hi_x) r.hi_x = p.x;
      if (p.y < r.lo_y) r.lo_y = p.y;
      if (p.y > r.hi_y) r.hi_y = p.y;
      return r;
   endfunction

   // Saturate to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [PT_BITS-1:0] v);
      logic signed [31:0] r;
      if (v > PT_BITS'(signed'(32'sh7FFFFFFF))) r = 32'sh7FFFFFFF;
      else if (v < PT_BITS'(signed'(32'sh80000000))) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== design/abb_cell.sv =====
module abb_cell (
   input  logic                         clock,
   input  logic                         load,
   input  logic [abb_pkg::IDX_BITS-1:0] shift_idx,
   input  abb_pkg::lane_type            lane_in  [abb_pkg::NUM_LANES],
   input  abb_pkg::tag_type             tag_in,
   output abb_pkg::lane_type            lane_out [abb_pkg::NUM_LANES],
   output abb_pkg::tag_type             tag_out
);

   abb_pkg::lane_type lane_ff [abb_pkg::NUM_LANES];
   abb_pkg::lane_type lane_in_next [abb_pkg::NUM_LANES];
   abb_pkg::tag_type  tag_ff;
   logic signed [abb_pkg::Z_BITS-1:0] atan_z;

   // One micro-rotation for each lane, direction from the sign of z.
   always_comb begin
      atan_z = abb_pkg::Z_BITS'(abb_pkg::ATAN_TURN[shift_idx]);
      for (int l = 0; l < abb_pkg::NUM_LANES; l++) begin
         if (!lane_in[l].z[abb_pkg::Z_BITS-1]) begin
            lane_in_next[l].x = lane_in[l].x - (lane_in[l].y >>> shift_idx);
            lane_in_next[l].y = lane_in[l].y + (lane_in[l].x >>> shift_idx);
            lane_in_next[l].z = lane_in[l].z - atan_z;
         end else begin
            lane_in_next[l].x = lane_in[l].x + (lane_in[l].y >>> shift_idx);
            lane_in_next[l].y = lane_in[l].y - (lane_in[l].x >>> shift_idx);
            lane_in_next[l].z = lane_in[l].z + atan_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in_next;
         tag_ff  <= tag_in;
      end
   end

   assign lane_out = lane_ff;
   assign tag_out  = tag_ff;

endmodule

// ===== design/abb_box.sv =====
module abb_box (
   input  logic              clock,
   input  logic              load_point,
   input  logic              load_fold,
   input  abb_pkg::lane_type lane_in [abb_pkg::NUM_LANES],
   input  abb_pkg::tag_type  tag_in,
   output logic              ok_out,
   output abb_pkg::box_type  box_a_out,
   output abb_pkg::box_type  box_b_out
);

   localparam int RB = abb_pkg::XY_BITS - 16;

   logic signed [RB-1:0] xr [abb_pkg::NUM_LANES];
   logic signed [RB-1:0] yr [abb_pkg::NUM_LANES];
   abb_pkg::point_type pt_in [6];
   abb_pkg::point_type pt_ff [6];
   logic [3:0]         on_ff;
   logic               ok_pt_ff;
   logic               ok_ff;
   abb_pkg::box_type   box_a_ff, box_b_ff;
   abb_pkg::box_type   box_a_in, box_b_in;

   // Quarter-turn rotation of a rounded offset, then the center is added.
   function automatic abb_pkg::point_type place(input logic [1:0] quad,
                                                input logic signed [RB-1:0] x,
                                                input logic signed [RB-1:0] y,
                                                input logic signed [31:0] cx,
                                                input logic signed [31:0] cy);
      logic signed [abb_pkg::PT_BITS-1:0] ex, ey, ox, oy;
      abb_pkg::point_type p;
      ex = abb_pkg::PT_BITS'(x);
      ey = abb_pkg::PT_BITS'(y);
      unique case (quad)
         2'd1:    begin ox = -ey; oy = ex;  end
         2'd2:    begin ox = -ex; oy = -ey; end
         2'd3:    begin ox = ey;  oy = -ex; end
         default: begin ox = ex;  oy = ey;  end
      endcase
      p.x = ox + abb_pkg::PT_BITS'(cx);
      p.y = oy + abb_pkg::PT_BITS'(cy);
      return p;
   endfunction

   // Round each lane from Q34.16 to a whole number, floor after adding one half.
   always_comb begin
      for (int l = 0; l < abb_pkg::NUM_LANES; l++) begin
         xr[l] = RB'((lane_in[l].x + abb_pkg::XY_BITS'(32768)) >>> 16);
         yr[l] = RB'((lane_in[l].y + abb_pkg::XY_BITS'(32768)) >>> 16);
      end
      pt_in[0] = place(tag_in.quad_start, xr[abb_pkg::LANE_START], yr[abb_pkg::LANE_START],
                       tag_in.cx, tag_in.cy);
      pt_in[1] = place(tag_in.quad_end, xr[abb_pkg::LANE_END], yr[abb_pkg::LANE_END],
                       tag_in.cx, tag_in.cy);
      for (int k = 0; k < 4; k++) begin
         pt_in[2+k] = place(2'(k), xr[abb_pkg::LANE_AXIS], yr[abb_pkg::LANE_AXIS],
                            tag_in.cx, tag_in.cy);
      end
   end

   always_ff @(posedge clock) begin
      if (load_point) begin
         pt_ff    <= pt_in;
         on_ff    <= tag_in.on_arc;
         ok_pt_ff <= tag_in.ok;
      end
   end

   // Start point with the first two axis points, end point with the last two.
   always_comb begin
      box_a_in = '{lo_x: pt_ff[0].x, lo_y: pt_ff[0].y, hi_x: pt_ff[0].x, hi_y: pt_ff[0].y};
      box_b_in = '{lo_x: pt_ff[1].x, lo_y: pt_ff[1].y, hi_x: pt_ff[1].x, hi_y: pt_ff[1].y};
      if (on_ff[0]) box_a_in = abb_pkg::grow(box_a_in, pt_ff[2]);
      if (on_ff[1]) box_a_in = abb_pkg::grow(box_a_in, pt_ff[3]);
      if (on_ff[2]) box_b_in = abb_pkg::grow(box_b_in, pt_ff[4]);
      if (on_ff[3]) box_b_in = abb_pkg::grow(box_b_in, pt_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (load_fold) begin
         box_a_ff <= box_a_in;
         box_b_ff <= box_b_in;
         ok_ff    <= ok_pt_ff;
      end
   end

   assign ok_out    = ok_ff;
   assign box_a_out = box_a_ff;
   assign box_b_out = box_b_ff;

endmodule

// ===== design/arc_bounding_box_core.sv =====
// Circular arc bounding box. Each word on the req_ channel is one arc
// (center, radius, start angle, signed sweep); each word on rsp_ is its
// axis-aligned box. The block takes one arc per cycle while req_stall is low
// and returns the box through one input stage with the gain multiplier, one
// cell per CORDIC iteration, a point stage, a fold stage and the output
// register. Three vectors rotate side by side in each cell (start
// point, end point and the shared axis point). Stages fill bubbles
// independently, so input keeps flowing while a result is stalled until
// every stage holds a word. The epsilon register is written on the csr_
// channel, which is always ready, and must only change while the block is
// empty.
module arc_bounding_box_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_arc_radius,
   input  logic [15:0]        req_start_angle,
   input  logic signed [17:0] req_sweep_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_box_valid,
   output logic signed [31:0] rsp_min_x,
   output logic signed [31:0] rsp_min_y,
   output logic signed [31:0] rsp_max_x,
   output logic signed [31:0] rsp_max_y,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_sweep_epsilon
);

   localparam int CS   = abb_pkg::CORDIC_STAGES;
   localparam int AB   = abb_pkg::ANGLE_BITS;
   localparam int NSTG = CS + 4;
   localparam int PT   = CS + 1;
   localparam int FOLD = CS + 2;
   localparam int OUTS = CS + 3;

   logic [7:0]      eps_ff;
   logic [NSTG-1:0] valid_ff, valid_in, load;

   abb_pkg::lane_type chain_lane [CS+1][abb_pkg::NUM_LANES];
   abb_pkg::tag_type  chain_tag  [CS+1];
   abb_pkg::lane_type seed_lane  [abb_pkg::NUM_LANES];

   logic [18:0]      mag, bound;
   logic [AB-1:0]    start_a, end_a, diff;
   logic             arc_ok;
   abb_pkg::tag_type tag_in, tag_ff;
   logic [62:0]      prod_ff;
   logic [AB-3:0]    resid_start_ff, resid_end_ff;

   logic             box_ok;
   abb_pkg::box_type box_a, box_b, box_m;

   logic               out_ok_ff;
   logic signed [31:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   // Epsilon register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_sweep_epsilon;
      end
   end

   // Each stage loads when it is empty or its word moves on.
   always_comb begin
      load[NSTG-1] = !valid_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];

   // Validity, end angle and on-arc flags for the four axis points.
   always_comb begin
      mag     = req_sweep_angle[17] ? 19'(-req_sweep_angle) : 19'(req_sweep_angle);
      bound   = mag + 19'(eps_ff);
      start_a = req_start_angle[AB-1:0];
      end_a   = start_a + req_sweep_angle[AB-1:0];
      arc_ok  = (req_arc_radius != '0) && (mag > 19'(eps_ff))
                && !(mag > 19'(1 << AB) + 19'(eps_ff));
      tag_in.ok         = arc_ok;
      tag_in.cx         = req_center_x;
      tag_in.cy         = req_center_y;
      tag_in.quad_start = start_a[AB-1 -: 2];
      tag_in.quad_end   = end_a[AB-1 -: 2];
      for (int k = 0; k < 4; k++) begin
         if (req_sweep_angle[17]) begin
            diff = start_a - {2'(k), (AB-2)'(0)};
         end else begin
            diff = {2'(k), (AB-2)'(0)} - start_a;
         end
         tag_in.on_arc[k] = (19'(diff) <= bound);
      end
   end

   // Input stage: radius times gain, start and end residual angles.
   always_ff @(posedge clock) begin
      if (load[0]) begin
         prod_ff        <= 63'(req_arc_radius) * 63'(abb_pkg::GAIN_Q32);
         tag_ff         <= tag_in;
         resid_start_ff <= start_a[AB-3:0];
         resid_end_ff   <= end_a[AB-3:0];
      end
   end

   // Seed vectors for the chain.
   always_comb begin
      for (int l = 0; l < abb_pkg::NUM_LANES; l++) begin
         seed_lane[l].x = abb_pkg::XY_BITS'(prod_ff[62:16]);
         seed_lane[l].y = '0;
      end
      seed_lane[abb_pkg::LANE_START].z =
         abb_pkg::Z_BITS'({resid_start_ff, (32-AB)'(0)});
      seed_lane[abb_pkg::LANE_END].z =
         abb_pkg::Z_BITS'({resid_end_ff, (32-AB)'(0)});
      seed_lane[abb_pkg::LANE_AXIS].z = '0;
   end

   assign chain_lane[0] = seed_lane;
   assign chain_tag[0]  = tag_ff;

   // Chain of CORDIC cells, one iteration each.
   for (genvar g = 0; g < CS; g++) begin : g_cell
      abb_cell u_cell (
         .clock     (clock),
         .load      (load[g+1]),
         .shift_idx (abb_pkg::IDX_BITS'(g)),
         .lane_in   (chain_lane[g]),
         .tag_in    (chain_tag[g]),
         .lane_out  (chain_lane[g+1]),
         .tag_out   (chain_tag[g+1])
      );
   end

   abb_box u_box (
      .clock      (clock),
      .load_point (load[PT]),
      .load_fold  (load[FOLD]),
      .lane_in    (chain_lane[CS]),
      .tag_in     (chain_tag[CS]),
      .ok_out     (box_ok),
      .box_a_out  (box_a),
      .box_b_out  (box_b)
   );

   // Merge the two partial boxes and saturate.
   always_comb begin
      box_m = box_a;
      if (box_b.lo_x < box_m.lo_x) box_m.lo_x = box_b.lo_x;
      if (box_b.lo_y < box_m.lo_y) box_m.lo_y = box_b.lo_y;
      if (box_b.hi_x > box_m.hi_x) box_m.hi_x = box_b.hi_x;
      if (box_b.hi_y > box_m.hi_y) box_m.hi_y = box_b.hi_y;
   end

   always_ff @(posedge clock) begin
      if (load[OUTS]) begin
         out_ok_ff <= box_ok;
         min_x_ff  <= box_ok ? abb_pkg::sat32(box_m.lo_x) : '0;
         min_y_ff  <= box_ok ? abb_pkg::sat32(box_m.lo_y) : '0;
         max_x_ff  <= box_ok ? abb_pkg::sat32(box_m.hi_x) : '0;
         max_y_ff  <= box_ok ? abb_pkg::sat32(box_m.hi_y) : '0;
      end
   end

   assign rsp_valid     = valid_ff[OUTS];
   assign rsp_box_valid = out_ok_ff;
   assign rsp_min_x     = min_x_ff;
   assign rsp_min_y     = min_y_ff;
   assign rsp_max_x     = max_x_ff;
   assign rsp_max_y     = max_y_ff;

`ifndef SYNTHESIS
   // Input stalls only when every stage holds a word and the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && (&valid_ff)))
      else $error("input stalled with room in the pipeline");

   // An empty box is all zeros.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_box_valid) |->
         (rsp_min_x == 0 && rsp_min_y == 0 && rsp_max_x == 0 && rsp_max_y == 0))
      else $error("invalid arc with nonzero box");

   // A valid box is ordered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_box_valid) |-> (rsp_min_x <= rsp_max_x && rsp_min_y <= rsp_max_y))
      else $error("box corners out of order");

   // Nothing emerges right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
